FILE: sv/hsc_pkg.sv
// shared types and constants for the history stack with cursor
package hsc_pkg;

    localparam int DEPTH      = 16;
    localparam int ENTRY_BITS = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    localparam logic [2:0] MODE_PUSH     = 3'd0;
    localparam logic [2:0] MODE_POP      = 3'd1;
    localparam logic [2:0] MODE_PEEK     = 3'd2;
    localparam logic [2:0] MODE_BACK     = 3'd3;
    localparam logic [2:0] MODE_FORWARD  = 3'd4;
    localparam logic [2:0] MODE_TRUNCATE = 3'd5;
    localparam logic [2:0] MODE_CLEAR    = 3'd6;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_EMPTY  = 3'd1;
    localparam logic [2:0] ST_FULL   = 3'd2;
    localparam logic [2:0] ST_OLDEST = 3'd3;
    localparam logic [2:0] ST_NEWEST = 3'd4;

    typedef struct packed {
        logic [2:0]            mode;
        logic [ENTRY_BITS-1:0] entry_value;
    } hsc_in_t;

    typedef struct packed {
        logic [ENTRY_BITS-1:0] result_value;
        logic [2:0]            status;
        logic [CNT_W-1:0]      fill_count;
        logic [IDX_W-1:0]      cursor_position;
    } hsc_out_t;

endpackage

FILE: sv/history_stack_with_cursor_top.sv
// history stack with navigation cursor, top level
//
// usage
//   in channel  : in_valid / in_ready / in_data (mode, entry_value)
//   out channel : out_valid / out_ready / out_data (result_value, status,
//                 fill_count, cursor_position)
//   every input transfer makes exactly one output transfer, in order
// timing
//   an accepted operation updates count and cursor at the accepting edge and
//   reads the entry store there into a registered read port; the result
//   register is loaded from the read stage once it is empty or being drained,
//   and out_valid rises when it is loaded
//   throughput is one operation per cycle while out_ready is high, set by the
//   single read and single write port of the 16 x 32 entry store
// stalls
//   when out_ready is low the result register holds, the read stage can still
//   take one more operation, then in_ready drops until the receiver drains
// reset
//   rst_n clears count, cursor and both valid flags; entry store contents are
//   not cleared, and only entries below the count ever reach result_value
module history_stack_with_cursor_top
    import hsc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  hsc_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output hsc_out_t out_data
);

    // where the result word comes from
    typedef enum logic [1:0] {
        SRC_ZERO = 2'd0,
        SRC_VAL  = 2'd1,
        SRC_MEM  = 2'd2
    } src_t;

    // entry store, one write and one registered read per cycle
    logic [ENTRY_BITS-1:0] mem [DEPTH];

    // architectural state
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] cur_reg, cur_next;

    // read stage
    logic                  a_valid_reg;
    logic                  a_zero_reg;
    logic [ENTRY_BITS-1:0] a_data_reg;
    logic [2:0]            a_status_reg;
    logic [CNT_W-1:0]      a_cnt_reg;
    logic [IDX_W-1:0]      a_cur_reg;

    // result register
    logic     b_valid_reg;
    hsc_out_t b_data_reg;

    logic                  accept;
    logic                  a_move;
    logic                  empty;
    logic                  full;
    logic [CNT_W-1:0]      cnt_m1;
    logic [CNT_W-1:0]      cur_ext;
    logic [CNT_W-1:0]      cur_p1;
    logic [IDX_W-1:0]      rd_addr;
    logic                  wr_en;
    logic [2:0]            status;
    src_t                  src;

    assign a_move   = a_valid_reg && (!b_valid_reg || out_ready);
    assign in_ready = !a_valid_reg || a_move;
    assign accept   = in_valid && in_ready;

    assign empty   = (cnt_reg == '0);
    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign cnt_m1  = cnt_reg - CNT_W'(1);
    assign cur_ext = CNT_W'(cur_reg);
    assign cur_p1  = cur_ext + CNT_W'(1);

    // operation decode, all from the current count and cursor
    always_comb
    begin
        cnt_next = cnt_reg;
        cur_next = cur_reg;
        rd_addr  = cur_reg;
        wr_en    = 1'b0;
        status   = ST_OK;
        src      = SRC_ZERO;
        case (in_data.mode)
            MODE_PUSH:
            begin
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    wr_en    = 1'b1;
                    cur_next = cnt_reg[IDX_W-1:0];
                    cnt_next = cnt_reg + CNT_W'(1);
                    src      = SRC_VAL;
                end
            end
            MODE_POP:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    cnt_next = cnt_m1;
                    rd_addr  = cnt_m1[IDX_W-1:0];
                    src      = SRC_MEM;
                    // clamp a cursor left above the new top
                    if (cnt_m1 == '0)
                    begin
                        cur_next = '0;
                    end
                    else if (cur_p1 >= cnt_reg)
                    begin
                        cur_next = IDX_W'(cnt_m1 - CNT_W'(1));
                    end
                end
            end
            MODE_PEEK:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    rd_addr = cnt_m1[IDX_W-1:0];
                    src     = SRC_MEM;
                end
            end
            MODE_BACK:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    src = SRC_MEM;
                    if (cur_reg == '0)
                    begin
                        status = ST_OLDEST;
                    end
                    else
                    begin
                        cur_next = cur_reg - IDX_W'(1);
                        rd_addr  = cur_reg - IDX_W'(1);
                    end
                end
            end
            MODE_FORWARD:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    src = SRC_MEM;
                    if (cur_p1 >= cnt_reg)
                    begin
                        status = ST_NEWEST;
                    end
                    else
                    begin
                        cur_next = cur_p1[IDX_W-1:0];
                        rd_addr  = cur_p1[IDX_W-1:0];
                    end
                end
            end
            MODE_TRUNCATE:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    cnt_next = cur_p1;
                    src      = SRC_MEM;
                end
            end
            MODE_CLEAR:
            begin
                cnt_next = '0;
                cur_next = '0;
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
    end

    // entry store write and registered read
    always_ff @(posedge clk)
    begin
        if (accept && wr_en)
        begin
            mem[cnt_reg[IDX_W-1:0]] <= in_data.entry_value;
        end
        if (accept)
        begin
            if (src == SRC_VAL)
            begin
                a_data_reg <= in_data.entry_value;
            end
            else
            begin
                a_data_reg <= mem[rd_addr];
            end
            a_zero_reg   <= (src == SRC_ZERO);
            a_status_reg <= status;
            a_cnt_reg    <= cnt_next;
            a_cur_reg    <= cur_next;
        end
        if (a_move)
        begin
            b_data_reg.result_value    <= a_zero_reg ? '0 : a_data_reg;
            b_data_reg.status          <= a_status_reg;
            b_data_reg.fill_count      <= a_cnt_reg;
            b_data_reg.cursor_position <= a_cur_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            cur_reg     <= '0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                cnt_reg <= cnt_next;
                cur_reg <= cur_next;
            end
            if (accept)
            begin
                a_valid_reg <= 1'b1;
            end
            else if (a_move)
            begin
                a_valid_reg <= 1'b0;
            end
            if (a_move)
            begin
                b_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                b_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = b_valid_reg;
    assign out_data  = b_data_reg;

    // cursor always points at a held entry, or rests at zero when empty
    a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0 && cur_reg == '0) || (CNT_W'(cur_reg) < cnt_reg))
        else $error("cursor outside held entries");

    // count never exceeds the store depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("count above depth");

    // a full read stage with a stalled result register blocks new input
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (a_valid_reg && b_valid_reg && !out_ready) |-> !in_ready)
        else $error("input taken while both stages held");

    // a stage handed to the result register shows up as a valid result
    a_move_valid: assert property (@(posedge clk) disable iff (!rst_n)
        a_move |=> b_valid_reg)
        else $error("result lost on stage move");

endmodule
